FILE: hdl/rtm_pkg.sv
`timescale 1ns / 1ps
// Package for the runtime meter register bank: transfer payload types,
// action and register codes, reset constants and the fan compare function.
// No dependencies.
package rtm_pkg;

  // Action codes of one input transfer
  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_PULSE = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_READ  = 2'd3
  } act_e;

  // Writable register numbers
  localparam logic [7:0] REG_LED_MASK = 8'd0;
  localparam logic [7:0] REG_FAN0     = 8'd1;
  localparam logic [7:0] REG_FAN1     = 8'd2;

  // Status flag bit positions
  localparam int unsigned PULSE_BIT = 4;
  localparam int unsigned BLINK_BIT = 7;

  // Reset values
  localparam logic [7:0] TPS_RESET      = 8'd100;
  localparam logic [7:0] LED_MASK_RESET = 8'h80;
  localparam logic [7:0] FAN_RESET      = 8'd201;

  // Fan percent limits
  localparam logic [7:0] PCT_MAX = 8'd100;
  localparam logic [6:0] PCT_MIN = 7'd15;

  localparam int unsigned CNT_W = 32;

  typedef struct packed {
    act_e       action;
    logic [3:0] run_lines;
    logic [7:0] reg_index;
    logic [7:0] write_value;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       index_error;
    logic       led_on;
    logic [7:0] fan0_compare;
    logic [7:0] fan1_compare;
  } out_t;

  // Percent to PWM compare: clamp to 100, lift 1..14 to 15,
  // then (100 - p) * 2, plus one when nonzero. Period is 200.
  function automatic logic [7:0] fan_compare(input logic [7:0] pct);
    logic [6:0] p;
    logic [7:0] v;
    p = (pct > PCT_MAX) ? PCT_MAX[6:0] : pct[6:0];
    if ((p != 7'd0) && (p < PCT_MIN)) begin
      p = PCT_MIN;
    end
    v = {PCT_MAX[6:0] - p, 1'b0};
    if (v != 8'd0) begin
      v = v + 8'd1;
    end
    return v;
  endfunction

endpackage

FILE: hdl/runtime_meter_register_bank_core.sv
`timescale 1ns / 1ps
// Top level of the runtime meter register bank: counter memory with
// read-modify-write pipeline, flag and register state, output register.
// Depends on rtm_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one action
//   per transfer: tick, meter pulse, register write or counter image read.
//   Output channel (out_valid_o / out_stall_i / out_data_o) returns exactly
//   one result per action, in order, with state seen after the action.
//   cfg_we_i / cfg_wdata_i write ticks_per_second; write only while idle.
// Pipeline: stage 1 register, then output register. Throughput: one action
//   per cycle while out_stall_i is low. Counters sit in a 2-row memory
//   (row 0 holds seconds and all runtime lanes, row 1 the pulse count) read
//   in the accept cycle and written back as the item leaves stage 1; a
//   write to the row being read is forwarded into the read register.
// Reset: all counters read as zero (per-row valid bits), flags clear,
//   LED mask 0x80, fan compares 201, ticks_per_second 100.
// Stall: the output register holds its result while out_stall_i is high;
//   the stall reaches in_stall_o once the internal stage is also full.
module runtime_meter_register_bank_core #(
  parameter int unsigned RUN_LINES   = 4,
  parameter int unsigned IMAGE_BYTES = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rtm_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rtm_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic [7:0]    cfg_wdata_i
);

  localparam int unsigned LANES = RUN_LINES + 1;
  localparam int unsigned ROW_W = LANES * rtm_pkg::CNT_W;
  localparam int unsigned CNT_W_T = rtm_pkg::CNT_W;

  // Handshake and pipeline control
  logic          s1_valid_q;
  rtm_pkg::in_t  s1_item_q;
  logic          s1_addr_q;
  logic          s1_fire;
  logic          in_xfer;
  logic          out_valid_q;
  rtm_pkg::out_t out_data_q;
  rtm_pkg::out_t out_data_d;

  assign s1_fire    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Counter memory, per-row valid bits
  logic [ROW_W-1:0] cnt_mem [2];
  logic [1:0]       row_vld_q;
  logic [ROW_W-1:0] rd_q;
  logic             rd_addr;
  logic             mem_we;
  logic [ROW_W-1:0] mem_wdata;

  // Row select: pulse count and image word 1 live in row 1
  assign rd_addr = (in_data_i.action == rtm_pkg::ACT_PULSE) ||
                   ((in_data_i.action == rtm_pkg::ACT_READ) &&
                    (in_data_i.reg_index[7:2] == 6'd1));

  // Read port with write-first forwarding
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      if (mem_we && (s1_addr_q == rd_addr)) begin
        rd_q <= mem_wdata;
      end else if (!row_vld_q[rd_addr]) begin
        rd_q <= '0;
      end else begin
        rd_q <= cnt_mem[rd_addr];
      end
    end
  end

  // Write port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cnt_mem[s1_addr_q] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else if (mem_we) begin
      row_vld_q[s1_addr_q] <= 1'b1;
    end
  end

  // Stage 1 register: item waiting on its memory read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_item_q <= in_data_i;
      s1_addr_q <= rd_addr;
    end
  end

  // Scalar state
  logic [7:0] tps_q;
  logic [7:0] prescale_q, prescale_d;
  logic [7:0] flags_q, flags_d;
  logic [7:0] led_mask_q, led_mask_d;
  logic [7:0] fan0_q, fan0_d;
  logic [7:0] fan1_q, fan1_d;

  // Action execution on the read row
  logic [7:0]         pre_inc;
  logic               second;
  logic [5:0]         word_sel;
  logic [CNT_W_T-1:0] rd_word;

  always_comb begin
    prescale_d = prescale_q;
    flags_d    = flags_q;
    led_mask_d = led_mask_q;
    fan0_d     = fan0_q;
    fan1_d     = fan1_q;
    mem_we     = 1'b0;
    mem_wdata  = rd_q;
    pre_inc    = prescale_q + 8'd1;
    second     = pre_inc >= tps_q;
    word_sel   = s1_item_q.reg_index[7:2];
    rd_word    = '0;
    out_data_d = '0;

    unique case (s1_item_q.action)
      rtm_pkg::ACT_TICK: begin
        prescale_d = second ? 8'd0 : pre_inc;
        if (second) begin
          mem_we = s1_fire;
          mem_wdata[CNT_W_T-1:0] = rd_q[CNT_W_T-1:0] + 32'd1;
          flags_d[rtm_pkg::BLINK_BIT] = ~flags_q[rtm_pkg::BLINK_BIT];
          for (int unsigned i = 0; i < RUN_LINES; i++) begin
            if (s1_item_q.run_lines[i]) begin
              mem_wdata[(i+1)*CNT_W_T +: CNT_W_T] =
                rd_q[(i+1)*CNT_W_T +: CNT_W_T] + 32'd1;
            end
            flags_d[i] = s1_item_q.run_lines[i];
          end
        end
      end
      rtm_pkg::ACT_PULSE: begin
        mem_we = s1_fire;
        mem_wdata[CNT_W_T-1:0] = rd_q[CNT_W_T-1:0] + 32'd1;
        flags_d[rtm_pkg::PULSE_BIT] = ~flags_q[rtm_pkg::PULSE_BIT];
      end
      rtm_pkg::ACT_WRITE: begin
        priority if (s1_item_q.reg_index == rtm_pkg::REG_LED_MASK) begin
          led_mask_d = s1_item_q.write_value;
        end else if (s1_item_q.reg_index == rtm_pkg::REG_FAN0) begin
          fan0_d = rtm_pkg::fan_compare(s1_item_q.write_value);
        end else if (s1_item_q.reg_index == rtm_pkg::REG_FAN1) begin
          fan1_d = rtm_pkg::fan_compare(s1_item_q.write_value);
        end else begin
          // other registers ignored
        end
      end
      rtm_pkg::ACT_READ: begin
        if (s1_item_q.reg_index < 8'(IMAGE_BYTES)) begin
          // words 0 and 1 are lane 0 of rows 0 and 1, runtime i is lane i+1
          if (word_sel < 6'd2) begin
            rd_word = rd_q[CNT_W_T-1:0];
          end
          for (int unsigned l = 1; l < LANES; l++) begin
            if (word_sel == 6'(l + 1)) begin
              rd_word = rd_q[l*CNT_W_T +: CNT_W_T];
            end
          end
          out_data_d.read_data = rd_word[s1_item_q.reg_index[1:0]*8 +: 8];
        end else begin
          out_data_d.index_error = 1'b1;
        end
      end
      default: begin
      end
    endcase

    out_data_d.led_on       = (flags_d & led_mask_d) != 8'd0;
    out_data_d.fan0_compare = fan0_d;
    out_data_d.fan1_compare = fan1_d;
  end

  // State update when the stage-1 item retires
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescale_q <= '0;
      flags_q    <= '0;
      led_mask_q <= rtm_pkg::LED_MASK_RESET;
      fan0_q     <= rtm_pkg::FAN_RESET;
      fan1_q     <= rtm_pkg::FAN_RESET;
    end else if (s1_fire) begin
      prescale_q <= prescale_d;
      flags_q    <= flags_d;
      led_mask_q <= led_mask_d;
      fan0_q     <= fan0_d;
      fan1_q     <= fan1_d;
    end
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= rtm_pkg::TPS_RESET;
    end else if (cfg_we_i) begin
      tps_q <= cfg_wdata_i;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
